FILE: hw/rtl/tpt_pkg.sv
package tpt_pkg;

    localparam int NODES    = 1024;
    localparam int ALPHABET = 26;

    localparam int IDX_W    = $clog2(NODES);
    localparam int FREE_W   = $clog2(NODES + 1);
    localparam int SLOT_W   = $clog2(ALPHABET);
    localparam int ROW_W    = ALPHABET * IDX_W;
    localparam int FUNC_W   = 2;
    localparam int LETTER_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd2;

    typedef logic [ALPHABET-1:0][IDX_W-1:0] t_row;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_in;

    typedef struct packed {
        logic found;
        logic pool_full;
    } t_out;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_MARK
    } t_state;

endpackage

FILE: hw/rtl/tpt_ram.sv
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tpt_ctrl.sv
module tpt_ctrl
    import tpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_item,
    output logic             o_done,
    output t_out             o_result,
    output logic             o_row_we,
    output logic [IDX_W-1:0] o_row_waddr,
    output t_row             o_row_wdata,
    output logic [IDX_W-1:0] o_row_raddr,
    input  t_row             i_row_rdata,
    output logic             o_mark_we,
    output logic [IDX_W-1:0] o_mark_waddr,
    output logic             o_mark_wdata,
    output logic [IDX_W-1:0] o_mark_raddr,
    input  logic             i_mark_rdata
);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr_addr, n_clr_addr;
    logic [FREE_W-1:0]   r_free, n_free;
    logic [IDX_W-1:0]    r_cursor, n_cursor;
    logic                r_broken, n_broken;
    logic                r_ovf, n_ovf;
    t_in                 r_in, n_in;
    logic                r_ok, n_ok;
    logic                r_full, n_full;
    logic                r_done, n_done;
    t_out                r_result, n_result;

    logic                accept;
    logic                letter_ok;
    logic [IDX_W-1:0]    child;
    logic [SLOT_W-1:0]   slot;
    logic                ok;
    t_row                row_new;

    assign accept    = start && (r_state == ST_IDLE);
    assign letter_ok = int'(r_in.letter) < ALPHABET;
    assign slot      = SLOT_W'(r_in.letter);
    assign child     = i_row_rdata[slot];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_in.last && r_in.func == FUNC_SEARCH) begin
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MARK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_free       = r_free;
        n_cursor     = r_cursor;
        n_broken     = r_broken;
        n_ovf        = r_ovf;
        n_in         = r_in;
        n_ok         = r_ok;
        n_full       = r_full;
        n_done       = 1'b0;
        n_result     = r_result;
        ok           = 1'b0;
        row_new      = i_row_rdata;
        o_row_we     = 1'b0;
        o_row_waddr  = r_cursor;
        o_row_wdata  = i_row_rdata;
        o_mark_we    = 1'b0;
        o_mark_waddr = r_cursor;
        o_mark_wdata = 1'b0;
        o_mark_raddr = r_cursor;

        case (r_state)
            ST_CLEAR: begin
                o_row_we     = 1'b1;
                o_row_waddr  = r_clr_addr;
                o_row_wdata  = '0;
                o_mark_we    = 1'b1;
                o_mark_waddr = r_clr_addr;
                o_mark_wdata = 1'b0;
                n_clr_addr   = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_in = i_item;
                end
            end
            ST_WALK: begin
                if (!letter_ok) begin
                    n_broken = 1'b1;
                end else if (!(r_broken || r_ovf ||
                        !(r_in.func == FUNC_INSERT || r_in.func == FUNC_SEARCH ||
                          r_in.func == FUNC_PREFIX))) begin
                    if (r_in.func == FUNC_INSERT) begin
                        if (child == '0) begin
                            if (r_free == FREE_W'(NODES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                row_new[slot] = r_free[IDX_W-1:0];
                                o_row_we      = 1'b1;
                                o_row_wdata   = row_new;
                                n_cursor      = r_free[IDX_W-1:0];
                                n_free        = r_free + 1'b1;
                            end
                        end else begin
                            n_cursor = child;
                        end
                    end else begin
                        if (child == '0) begin
                            n_broken = 1'b1;
                        end else begin
                            n_cursor = child;
                        end
                    end
                end

                o_mark_raddr = n_cursor;
                o_mark_waddr = n_cursor;
                if (r_in.last) begin
                    ok     = !n_broken && !n_ovf;
                    n_ok   = ok;
                    n_full = n_ovf;
                    case (r_in.func)
                        FUNC_INSERT: begin
                            o_mark_we       = ok;
                            o_mark_wdata    = 1'b1;
                            n_done          = 1'b1;
                            n_result.found  = ok;
                        end
                        FUNC_SEARCH: begin
                            n_done          = 1'b0;
                        end
                        FUNC_PREFIX: begin
                            n_done          = 1'b1;
                            n_result.found  = ok;
                        end
                        default: begin
                            n_done          = 1'b1;
                            n_result.found  = 1'b0;
                        end
                    endcase
                    n_result.pool_full = n_ovf;
                    n_cursor = '0;
                    n_broken = 1'b0;
                    n_ovf    = 1'b0;
                end
            end
            ST_MARK: begin
                n_done             = 1'b1;
                n_result.found     = r_ok && i_mark_rdata;
                n_result.pool_full = r_full;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_free     <= FREE_W'(1);
            r_cursor   <= '0;
            r_broken   <= 1'b0;
            r_ovf      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_free     <= n_free;
            r_cursor   <= n_cursor;
            r_broken   <= n_broken;
            r_ovf      <= n_ovf;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_ok     <= n_ok;
        r_full   <= n_full;
        r_result <= n_result;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_row_raddr = r_cursor;

endmodule

FILE: hw/rtl/trie_prefix_table_unit.sv
// one letter per transaction: busy after start while the node row is read, and after the last letter of a
// search also while the word mark is read; no new letter is taken while busy
// the result is registered: o_done is raised after the walk state for insert and prefix, and after the mark state for
// search (one extra read of the word mark memory)
// synchronous active-low reset, then a clearing pass over all 1024 entries of the node
// and mark memories with busy high; results cannot be stalled by the receiver
module trie_prefix_table_unit
    import tpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_done,
    output t_out o_result
);

    logic             row_we;
    logic [IDX_W-1:0] row_waddr;
    t_row             row_wdata;
    logic [IDX_W-1:0] row_raddr;
    t_row             row_rdata;
    logic             mark_we;
    logic [IDX_W-1:0] mark_waddr;
    logic             mark_wdata;
    logic [IDX_W-1:0] mark_raddr;
    logic             mark_rdata;

    tpt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_done       (o_done),
        .o_result     (o_result),
        .o_row_we     (row_we),
        .o_row_waddr  (row_waddr),
        .o_row_wdata  (row_wdata),
        .o_row_raddr  (row_raddr),
        .i_row_rdata  (row_rdata),
        .o_mark_we    (mark_we),
        .o_mark_waddr (mark_waddr),
        .o_mark_wdata (mark_wdata),
        .o_mark_raddr (mark_raddr),
        .i_mark_rdata (mark_rdata)
    );

    // child index rows, one per node
    tpt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // word marks
    tpt_ram #(
        .WIDTH (1),
        .DEPTH (NODES)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

endmodule
